>>> hw/rtl/hash_grid_neighbor_search_defines.svh
// assertion macros for the hash grid neighbor search checker
// no dependencies; included by the checker file only
`ifndef HASH_GRID_NEIGHBOR_SEARCH_DEFINES_SVH
`define HASH_GRID_NEIGHBOR_SEARCH_DEFINES_SVH

// same-cycle implication, idle in reset
`define HGNS_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hgns check failed");

// next-cycle implication, idle in reset
`define HGNS_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hgns check failed");

`endif

>>> hw/rtl/hgns_pkg.sv
// types, constants and small helpers of the hash grid neighbor search
// no dependencies; imported by hgns_ctrl, hgns_dp, the top level and the testbench
package hgns_pkg;

    localparam int MAX_POINTS   = 512;
    localparam int MAX_CELLS    = 4096;
    localparam int BUCKET_DEPTH = 8;
    localparam int MAX_RESULTS  = 64;
    localparam int PIDX_W       = 9;
    localparam int CNT_W        = 10;
    localparam int KEY_W        = 12;
    localparam int SLOT_W       = 3;
    localparam int FILL_W       = 4;
    localparam int NCNT_W       = 7;

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_ADD   = 2'd1,
        REQ_QALL  = 2'd2,
        REQ_QANY  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_FULL    = 3'd1,
        STAT_MATCH   = 3'd2,
        STAT_NOMATCH = 3'd3,
        STAT_ANY     = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        REG_RES_X   = 2'd0,
        REG_RES_Y   = 2'd1,
        REG_RES_Z   = 2'd2,
        REG_INV_SPC = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_RSWEEP, ST_IDLE, ST_DISP, ST_CSWEEP, ST_MUL, ST_MOD, ST_KEY, ST_FRD,
        ST_FCHK, ST_ENT, ST_ENTW, ST_PTW, ST_SQ, ST_TEST, ST_NEXT, ST_FIN
    } t_state;

    typedef enum logic [2:0] {
        MS_X, MS_Y, MS_Z, MS_R, MS_DX, MS_DY, MS_DZ
    } t_msel;

    typedef enum logic [2:0] {
        CAP_NONE, CAP_X, CAP_Y, CAP_Z, CAP_R, CAP_ACC0, CAP_ACC
    } t_cap;

    typedef enum logic [3:0] {
        EM_NONE, EM_CLEAR, EM_ADD_OK, EM_FULL, EM_ANY_HIT, EM_ANY_MISS,
        EM_PEND, EM_PEND_LAST, EM_NOMATCH
    } t_emit;

    typedef struct packed {
        logic  load;
        logic  count_clr;
        logic  sweep;
        t_msel msel;
        t_cap  cap;
        logic  mod_init;
        logic  mod_step;
        logic  key_load;
        logic  fill_rd;
        logic  add_wr;
        logic  j_clr;
        logic  j_inc;
        logic  ent_rd;
        logic  pt_rd;
        logic  diff_load;
        logic  i_clr;
        logic  i_inc;
        logic  pend_load;
        t_emit emit;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic sweep_last;
        logic store_full;
        logic bucket_full;
        logic j_done;
        logic hit;
        logic n_full;
        logic pend_valid;
        logic i_last;
    } t_stat;

    // out-of-range resolution clamps into 1..16
    function automatic logic [4:0] eff_res(input logic [4:0] r);
        logic [4:0] v;
        if (r == 5'd0) v = 5'd1;
        else if (r > 5'd16) v = 5'd16;
        else v = r;
        return v;
    endfunction

    // two restoring remainder steps, one per incoming bit
    function automatic logic [3:0] mod2(input logic [3:0] rem, input logic [1:0] b,
                                        input logic [4:0] r);
        logic [4:0] t;
        t = {rem, b[1]};
        if (t >= r) t = t - r;
        t = {t[3:0], b[0]};
        if (t >= r) t = t - r;
        return t[3:0];
    endfunction

endpackage

>>> hw/rtl/hgns_ctrl.sv
// sequencer of the hash grid neighbor search
// depends on hgns_pkg; drives hgns_dp through t_cmd and reads t_stat
module hgns_ctrl
    import hgns_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    t_state     r_state, n_state;
    logic [3:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RSWEEP;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.msel = MS_X;
        o_cmd.cap  = CAP_NONE;
        o_cmd.emit = EM_NONE;
        case (r_state)
            ST_RSWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DISP;
                end
            end
            ST_DISP: begin
                n_step = '0;
                if (i_stat.req == REQ_CLEAR) begin
                    o_cmd.count_clr = 1'b1;
                    n_state         = ST_CSWEEP;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_CSWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) begin
                    o_cmd.emit = EM_CLEAR;
                    n_state    = ST_IDLE;
                end
            end
            ST_MUL: begin
                n_step = r_step + 4'd1;
                case (r_step)
                    4'd0: o_cmd.msel = MS_X;
                    4'd1: begin
                        o_cmd.msel = MS_Y;
                        o_cmd.cap  = CAP_X;
                    end
                    4'd2: begin
                        o_cmd.msel = MS_Z;
                        o_cmd.cap  = CAP_Y;
                    end
                    4'd3: begin
                        o_cmd.msel = MS_R;
                        o_cmd.cap  = CAP_Z;
                    end
                    default: begin
                        o_cmd.cap      = CAP_R;
                        o_cmd.mod_init = 1'b1;
                        n_step         = '0;
                        n_state        = ST_MOD;
                    end
                endcase
            end
            ST_MOD: begin
                o_cmd.mod_step = 1'b1;
                n_step         = r_step + 4'd1;
                if (r_step == 4'd15) begin
                    o_cmd.i_clr = 1'b1;
                    n_state     = ST_KEY;
                end
            end
            ST_KEY: begin
                o_cmd.key_load = 1'b1;
                n_state        = ST_FRD;
            end
            ST_FRD: begin
                o_cmd.fill_rd = 1'b1;
                n_state       = ST_FCHK;
            end
            ST_FCHK: begin
                if (i_stat.req == REQ_ADD) begin
                    if (i_stat.store_full || i_stat.bucket_full) begin
                        o_cmd.emit = EM_FULL;
                    end else begin
                        o_cmd.add_wr = 1'b1;
                        o_cmd.emit   = EM_ADD_OK;
                    end
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.j_clr = 1'b1;
                    n_state     = ST_ENT;
                end
            end
            ST_ENT: begin
                if (i_stat.j_done) begin
                    n_state = ST_NEXT;
                end else begin
                    o_cmd.ent_rd = 1'b1;
                    n_state      = ST_ENTW;
                end
            end
            ST_ENTW: begin
                o_cmd.pt_rd = 1'b1;
                n_state     = ST_PTW;
            end
            ST_PTW: begin
                o_cmd.diff_load = 1'b1;
                n_step          = '0;
                n_state         = ST_SQ;
            end
            ST_SQ: begin
                n_step = r_step + 4'd1;
                case (r_step)
                    4'd0: o_cmd.msel = MS_DX;
                    4'd1: begin
                        o_cmd.msel = MS_DY;
                        o_cmd.cap  = CAP_ACC0;
                    end
                    4'd2: begin
                        o_cmd.msel = MS_DZ;
                        o_cmd.cap  = CAP_ACC;
                    end
                    default: begin
                        o_cmd.cap = CAP_ACC;
                        n_state   = ST_TEST;
                    end
                endcase
            end
            ST_TEST: begin
                o_cmd.j_inc = 1'b1;
                n_state     = ST_ENT;
                if (i_stat.hit) begin
                    if (i_stat.req == REQ_QANY) begin
                        o_cmd.emit = EM_ANY_HIT;
                        n_state    = ST_IDLE;
                    end else if (!i_stat.n_full) begin
                        o_cmd.pend_load = 1'b1;
                        if (i_stat.pend_valid) o_cmd.emit = EM_PEND;
                    end
                end
            end
            ST_NEXT: begin
                if (i_stat.i_last) begin
                    n_state = ST_FIN;
                end else begin
                    o_cmd.i_inc = 1'b1;
                    n_state     = ST_KEY;
                end
            end
            ST_FIN: begin
                if (i_stat.req == REQ_QANY) o_cmd.emit = EM_ANY_MISS;
                else if (i_stat.pend_valid) o_cmd.emit = EM_PEND_LAST;
                else o_cmd.emit = EM_NOMATCH;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

>>> hw/rtl/hgns_dp.sv
// datapath of the hash grid neighbor search: multiplier, wrap lanes, memories
// depends on hgns_pkg; commanded by hgns_ctrl
module hgns_dp
    import hgns_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic [1:0]         i_req_type,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic [30:0]        i_radius,
    input  logic [4:0]         i_res_x,
    input  logic [4:0]         i_res_y,
    input  logic [4:0]         i_res_z,
    input  logic [31:0]        i_inv_spacing,
    output logic               o_valid,
    output logic [2:0]         o_status,
    output logic [8:0]         o_point_index,
    output logic signed [31:0] o_pt_x,
    output logic signed [31:0] o_pt_y,
    output logic signed [31:0] o_pt_z,
    output logic               o_found,
    output logic               o_last
);

    logic [95:0]         pt_mem   [MAX_POINTS];
    logic [PIDX_W-1:0]   ent_mem  [MAX_CELLS*BUCKET_DEPTH];
    logic [FILL_W-1:0]   fill_mem [MAX_CELLS];

    t_req                r_req;
    logic signed [31:0]  r_pos   [3];
    logic [30:0]         r_rad;
    logic signed [65:0]  r_prod;
    logic signed [31:0]  r_cell  [3];
    logic                r_up    [3];
    logic                r_neg   [3];
    logic [31:0]         r_mag   [3];
    logic [3:0]          r_rem   [3];
    logic [61:0]         r_r2;
    logic [30:0]         r_ad    [3];
    logic                r_far   [3];
    logic [63:0]         r_acc;
    logic [CNT_W-1:0]    r_count;
    logic [KEY_W-1:0]    r_sweep;
    logic [KEY_W-1:0]    r_key;
    logic [FILL_W-1:0]   r_fill_q;
    logic [PIDX_W-1:0]   r_ent_q;
    logic [95:0]         r_pt_q;
    logic [2:0]          r_i;
    logic [FILL_W-1:0]   r_j;
    logic                r_pend_v;
    logic [PIDX_W-1:0]   r_pend_idx;
    logic [95:0]         r_pend_pt;
    logic [NCNT_W-1:0]   r_n;
    logic                r_valid;
    t_status             r_status;
    logic [PIDX_W-1:0]   r_pidx;
    logic [95:0]         r_opt;
    logic                r_found;
    logic                r_last;

    logic [4:0]          res     [3];
    logic [3:0]          wrapped [3];
    logic [3:0]          nb      [3];
    logic signed [32:0]  mul_a, mul_b;
    logic [12:0]         key_full;
    logic [95:0]         pt_cur;

    assign res[0] = eff_res(i_res_x);
    assign res[1] = eff_res(i_res_y);
    assign res[2] = eff_res(i_res_z);

    // operand select of the shared multiplier
    always_comb begin
        mul_b = $signed({1'b0, i_inv_spacing});
        case (i_cmd.msel)
            MS_X: mul_a = $signed({r_pos[0][31], r_pos[0]});
            MS_Y: mul_a = $signed({r_pos[1][31], r_pos[1]});
            MS_Z: mul_a = $signed({r_pos[2][31], r_pos[2]});
            MS_R: begin
                mul_a = $signed({2'b00, r_rad});
                mul_b = $signed({2'b00, r_rad});
            end
            MS_DX: begin
                mul_a = $signed({2'b00, r_ad[0]});
                mul_b = $signed({2'b00, r_ad[0]});
            end
            MS_DY: begin
                mul_a = $signed({2'b00, r_ad[1]});
                mul_b = $signed({2'b00, r_ad[1]});
            end
            MS_DZ: begin
                mul_a = $signed({2'b00, r_ad[2]});
                mul_b = $signed({2'b00, r_ad[2]});
            end
            default: mul_a = '0;
        endcase
    end

    // wrapped cells and the neighbor step picked by the key index bits
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            wrapped[k] = (r_neg[k] && r_rem[k] != 4'd0) ? 4'(res[k] - {1'b0, r_rem[k]})
                                                         : r_rem[k];
            nb[k] = wrapped[k];
            if (r_i[2-k]) begin
                if (r_up[k]) nb[k] = ({1'b0, wrapped[k]} + 5'd1 == res[k]) ? 4'd0
                                                                          : wrapped[k] + 4'd1;
                else nb[k] = (wrapped[k] == 4'd0) ? 4'(res[k] - 5'd1) : wrapped[k] - 4'd1;
            end
        end
        key_full = 13'(((9'(nb[2]) * 9'(res[1]) + 9'(nb[1])) * 13'(res[0])) + 13'(nb[0]));
    end

    assign pt_cur = {r_pos[0], r_pos[1], r_pos[2]};

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep) fill_mem[r_sweep] <= '0;
        else if (i_cmd.add_wr) fill_mem[r_key] <= r_fill_q + 4'd1;
        if (i_cmd.fill_rd) r_fill_q <= fill_mem[r_key];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_wr) ent_mem[{r_key, r_fill_q[SLOT_W-1:0]}] <= r_count[PIDX_W-1:0];
        if (i_cmd.ent_rd) r_ent_q <= ent_mem[{r_key, r_j[SLOT_W-1:0]}];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_wr) pt_mem[r_count[PIDX_W-1:0]] <= pt_cur;
        if (i_cmd.pt_rd) r_pt_q <= pt_mem[r_ent_q];
    end

    // arithmetic payload
    always_ff @(posedge i_clk) begin
        logic signed [32:0] d;
        logic [32:0]        ad;
        r_prod <= mul_a * mul_b;
        if (i_cmd.load) begin
            r_req    <= t_req'(i_req_type);
            r_pos[0] <= i_pos_x;
            r_pos[1] <= i_pos_y;
            r_pos[2] <= i_pos_z;
            r_rad    <= i_radius;
        end
        case (i_cmd.cap)
            CAP_X: begin
                r_cell[0] <= r_prod[63:32];
                r_up[0]   <= r_prod[31];
            end
            CAP_Y: begin
                r_cell[1] <= r_prod[63:32];
                r_up[1]   <= r_prod[31];
            end
            CAP_Z: begin
                r_cell[2] <= r_prod[63:32];
                r_up[2]   <= r_prod[31];
            end
            CAP_R:    r_r2  <= r_prod[61:0];
            CAP_ACC0: r_acc <= {2'b00, r_prod[61:0]};
            CAP_ACC:  r_acc <= r_acc + {2'b00, r_prod[61:0]};
            default: ;
        endcase
        for (int k = 0; k < 3; k++) begin
            if (i_cmd.mod_init) begin
                r_neg[k] <= r_cell[k][31];
                r_mag[k] <= r_cell[k][31] ? (~r_cell[k] + 32'd1) : r_cell[k];
                r_rem[k] <= '0;
            end else if (i_cmd.mod_step) begin
                r_rem[k] <= mod2(r_rem[k], r_mag[k][31:30], res[k]);
                r_mag[k] <= {r_mag[k][29:0], 2'b00};
            end
            if (i_cmd.diff_load) begin
                d  = $signed({r_pt_q[95-32*k], r_pt_q[95-32*k -: 32]})
                   - $signed({r_pos[k][31], r_pos[k]});
                ad = d[32] ? 33'(-d) : 33'(d);
                r_ad[k]  <= ad[30:0];
                r_far[k] <= (ad[32:31] != 2'b00);
            end
        end
        if (i_cmd.key_load) r_key <= key_full[KEY_W-1:0];
        if (i_cmd.pend_load) begin
            r_pend_idx <= r_ent_q;
            r_pend_pt  <= r_pt_q;
        end
    end

    // control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_sweep  <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_pend_v <= 1'b0;
            r_n      <= '0;
        end else begin
            if (i_cmd.count_clr) r_count <= '0;
            else if (i_cmd.add_wr) r_count <= r_count + 1'b1;
            if (i_cmd.sweep) r_sweep <= r_sweep + 1'b1;
            if (i_cmd.i_clr) r_i <= '0;
            else if (i_cmd.i_inc) r_i <= r_i + 3'd1;
            if (i_cmd.j_clr) r_j <= '0;
            else if (i_cmd.j_inc) r_j <= r_j + 4'd1;
            if (i_cmd.load) begin
                r_pend_v <= 1'b0;
                r_n      <= '0;
            end else if (i_cmd.pend_load) begin
                r_pend_v <= 1'b1;
                r_n      <= r_n + 1'b1;
            end
        end
    end

    // result register, one strobed beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else r_valid <= (i_cmd.emit != EM_NONE);
    end

    always_ff @(posedge i_clk) begin
        r_pidx  <= '0;
        r_opt   <= '0;
        r_found <= 1'b0;
        r_last  <= 1'b1;
        case (i_cmd.emit)
            EM_CLEAR:  r_status <= STAT_OK;
            EM_ADD_OK: begin
                r_status <= STAT_OK;
                r_pidx   <= r_count[PIDX_W-1:0];
            end
            EM_FULL:   r_status <= STAT_FULL;
            EM_ANY_HIT: begin
                r_status <= STAT_ANY;
                r_pidx   <= r_ent_q;
                r_opt    <= r_pt_q;
                r_found  <= 1'b1;
            end
            EM_ANY_MISS: r_status <= STAT_ANY;
            EM_PEND: begin
                r_status <= STAT_MATCH;
                r_pidx   <= r_pend_idx;
                r_opt    <= r_pend_pt;
                r_last   <= 1'b0;
            end
            EM_PEND_LAST: begin
                r_status <= STAT_MATCH;
                r_pidx   <= r_pend_idx;
                r_opt    <= r_pend_pt;
            end
            EM_NOMATCH: r_status <= STAT_NOMATCH;
            default:    r_status <= STAT_OK;
        endcase
    end

    assign o_stat.req         = r_req;
    assign o_stat.sweep_last  = &r_sweep;
    assign o_stat.store_full  = (r_count >= CNT_W'(MAX_POINTS));
    assign o_stat.bucket_full = (r_fill_q >= FILL_W'(BUCKET_DEPTH));
    assign o_stat.j_done      = (r_j >= r_fill_q);
    assign o_stat.hit         = !(r_far[0] || r_far[1] || r_far[2]) && (r_acc <= {2'b00, r_r2});
    assign o_stat.n_full      = (r_n >= NCNT_W'(MAX_RESULTS));
    assign o_stat.pend_valid  = r_pend_v;
    assign o_stat.i_last      = (r_i == 3'd7);

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_point_index = r_pidx;
    assign o_pt_x        = r_opt[95:64];
    assign o_pt_y        = r_opt[63:32];
    assign o_pt_z        = r_opt[31:0];
    assign o_found       = r_found;
    assign o_last        = r_last;

endmodule

>>> hw/rtl/hash_grid_neighbor_search.sv
// top level of the hash grid neighbor search: config registers, sequencer, datapath
// depends on hgns_pkg, hgns_ctrl and hgns_dp
//
// channel   | handshake               | payload
// ----------+-------------------------+----------------------------------------------
// config    | psel/penable/pwrite     | paddr, pwdata, prdata (pready tied high)
// request   | start while busy low    | i_req_type, i_pos_x/y/z, i_radius
// result    | o_valid strobe          | o_status, o_point_index, o_pt_x/y/z, o_found,
//           |                         | o_last
//
// one request at a time; busy stays high until its last beat has been issued
// after reset the bucket fill table is swept to zero while busy is high
// clear repeats the same sweep; a beat shows in the cycle after its emit
// query: setup on one shared 33x33 multiplier and 16 remainder steps, then each bucket
//   and each stored entry in turn, bound by the multiplier that forms the three squared
//   distances in turn, and a finish step
// results leave as single-cycle beats that the receiver cannot hold off
module hash_grid_neighbor_search
    import hgns_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_req_type,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic [30:0]        i_radius,
    output logic               o_valid,
    output logic [2:0]         o_status,
    output logic [8:0]         o_point_index,
    output logic signed [31:0] o_pt_x,
    output logic signed [31:0] o_pt_y,
    output logic signed [31:0] o_pt_z,
    output logic               o_found,
    output logic               o_last
);

    logic [4:0]  r_res_x, r_res_y, r_res_z;
    logic [31:0] r_inv_spacing;
    t_reg_idx    reg_idx;
    logic        cfg_wr;
    t_cmd        cmd;
    t_stat       stat;

    // register index from the word address
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_x       <= 5'd8;
            r_res_y       <= 5'd8;
            r_res_z       <= 5'd8;
            r_inv_spacing <= 32'd65536;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_RES_X:   r_res_x       <= pwdata[4:0];
                REG_RES_Y:   r_res_y       <= pwdata[4:0];
                REG_RES_Z:   r_res_z       <= pwdata[4:0];
                REG_INV_SPC: r_inv_spacing <= pwdata;
                default: ;
            endcase
        end
    end

    // readback
    always_comb begin
        case (reg_idx)
            REG_RES_X:   prdata = {27'd0, r_res_x};
            REG_RES_Y:   prdata = {27'd0, r_res_y};
            REG_RES_Z:   prdata = {27'd0, r_res_z};
            REG_INV_SPC: prdata = r_inv_spacing;
            default:     prdata = '0;
        endcase
    end

    hgns_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    hgns_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_req_type    (i_req_type),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_radius      (i_radius),
        .i_res_x       (r_res_x),
        .i_res_y       (r_res_y),
        .i_res_z       (r_res_z),
        .i_inv_spacing (r_inv_spacing),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_point_index (o_point_index),
        .o_pt_x        (o_pt_x),
        .o_pt_y        (o_pt_y),
        .o_pt_z        (o_pt_z),
        .o_found       (o_found),
        .o_last        (o_last)
    );

endmodule

>>> hw/rtl/hgns_checker.sv
// port-level checks of the hash grid neighbor search, bound to the top level
// depends on hash_grid_neighbor_search_defines.svh
`include "hash_grid_neighbor_search_defines.svh"

module hgns_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid,
    input logic o_found,
    input logic o_last
);

    // an accepted request keeps the block busy
    `HGNS_NEXT(a_accept_busy, start && !busy, busy)
    // a result beat only follows a busy cycle
    `HGNS_IMPLIES(a_beat_after_busy, o_valid, $past(busy))
    // more beats pending means the request is still in flight
    `HGNS_IMPLIES(a_more_busy, o_valid && !o_last, busy)
    // an any-query answer is always the final beat
    `HGNS_IMPLIES(a_found_last, o_valid && o_found, o_last)

endmodule

bind hash_grid_neighbor_search hgns_checker u_hgns_checker (.*);

>>> verif/testbench.sv
// self-checking testbench for the hash grid neighbor search
// depends on hgns_pkg and hash_grid_neighbor_search; needs nothing else
module testbench;
    import hgns_pkg::*;

    typedef struct {
        t_status     status;
        logic [8:0]  point_index;
        logic [31:0] pt_x, pt_y, pt_z;
        logic        found;
        logic        last;
    } t_beat;

    // tracks the point store and buckets, predicts the result beats of each request
    class grid_scoreboard;
        logic [31:0] px_mem [MAX_POINTS];
        logic [31:0] py_mem [MAX_POINTS];
        logic [31:0] pz_mem [MAX_POINTS];
        int          n_points;
        int          fill [MAX_CELLS];
        int          slot [MAX_CELLS][BUCKET_DEPTH];
        logic [4:0]  res [3];
        logic [31:0] inv_spc;
        t_beat       pending [$];
        int          errors;

        function new();
            n_points = 0;
            foreach (fill[k]) fill[k] = 0;
            res[0] = 5'd8; res[1] = 5'd8; res[2] = 5'd8;
            inv_spc = 32'h0001_0000;
            errors = 0;
        endfunction

        function void set_reg(t_reg_idx r, logic [31:0] v);
            if (r == REG_INV_SPC) inv_spc = v;
            else res[r] = v[4:0];
        endfunction

        function longint clamp_res(int a);
            if (res[a] == 0) return 1;
            if (res[a] > 16) return 16;
            return longint'(res[a]);
        endfunction

        // floor of pos * inv_spacing and whether the origin is in the upper half cell
        function longint cell_of(logic signed [31:0] p, output logic upper);
            longint prod;
            prod = longint'(p) * longint'({32'd0, inv_spc});
            upper = prod[31];
            return prod >>> 32;
        endfunction

        function int hash_key(longint cx, longint cy, longint cz);
            longint c [3];
            longint w [3];
            c[0] = cx; c[1] = cy; c[2] = cz;
            for (int a = 0; a < 3; a++) begin
                w[a] = c[a] % clamp_res(a);
                if (w[a] < 0) w[a] += clamp_res(a);
            end
            return int'(((w[2] * clamp_res(1) + w[1]) * clamp_res(0) + w[0]) % MAX_CELLS);
        endfunction

        function bit is_near(int idx, logic signed [31:0] qx, logic signed [31:0] qy,
                             logic signed [31:0] qz, longint unsigned r2);
            longint d [3];
            longint unsigned acc;
            d[0] = longint'($signed(px_mem[idx])) - longint'(qx);
            d[1] = longint'($signed(py_mem[idx])) - longint'(qy);
            d[2] = longint'($signed(pz_mem[idx])) - longint'(qz);
            acc = 0;
            for (int a = 0; a < 3; a++) begin
                if (d[a] < 0) d[a] = -d[a];
                if (d[a] >= 64'h8000_0000) return 0;
                acc += longint'(unsigned'(d[a] * d[a]));
            end
            return acc <= r2;
        endfunction

        function void push(t_status st, int idx, bit with_pt, bit fnd, bit lst);
            t_beat b;
            b.status      = st;
            b.point_index = idx[8:0];
            b.pt_x        = with_pt ? px_mem[idx] : 32'd0;
            b.pt_y        = with_pt ? py_mem[idx] : 32'd0;
            b.pt_z        = with_pt ? pz_mem[idx] : 32'd0;
            b.found       = fnd;
            b.last        = lst;
            pending = {pending, b};
        endfunction

        // accepted request: update the shadow store and queue its beats
        function void note_request(t_req rq, logic signed [31:0] qx, logic signed [31:0] qy,
                                   logic signed [31:0] qz, logic [30:0] rad);
            logic ux, uy, uz;
            longint cx, cy, cz;
            int key, n, idx;
            longint unsigned r2;
            cx = cell_of(qx, ux);
            cy = cell_of(qy, uy);
            cz = cell_of(qz, uz);
            case (rq)
                REQ_CLEAR: begin
                    n_points = 0;
                    foreach (fill[k]) fill[k] = 0;
                    push(STAT_OK, 0, 0, 0, 1);
                end
                REQ_ADD: begin
                    key = hash_key(cx, cy, cz);
                    if (n_points >= MAX_POINTS || fill[key] >= BUCKET_DEPTH) begin
                        push(STAT_FULL, 0, 0, 0, 1);
                    end else begin
                        px_mem[n_points] = qx;
                        py_mem[n_points] = qy;
                        pz_mem[n_points] = qz;
                        slot[key][fill[key]] = n_points;
                        fill[key]++;
                        push(STAT_OK, n_points, 0, 0, 1);
                        n_points++;
                    end
                end
                default: begin
                    r2 = longint'(rad) * longint'(rad);
                    n = 0;
                    // the 8 neighbor cells: bit 2 moves x, bit 1 y, bit 0 z
                    for (int i = 0; i < 8; i++) begin
                        key = hash_key(cx + (i[2] ? (ux ? 1 : -1) : 0),
                                       cy + (i[1] ? (uy ? 1 : -1) : 0),
                                       cz + (i[0] ? (uz ? 1 : -1) : 0));
                        for (int j = 0; j < fill[key]; j++) begin
                            idx = slot[key][j];
                            if (!is_near(idx, qx, qy, qz, r2)) continue;
                            if (rq == REQ_QANY) begin
                                push(STAT_ANY, idx, 1, 1, 1);
                                return;
                            end
                            if (n < MAX_RESULTS) begin
                                push(STAT_MATCH, idx, 1, 0, 0);
                                n++;
                            end
                        end
                    end
                    if (rq == REQ_QANY) push(STAT_ANY, 0, 0, 0, 1);
                    else if (n == 0) push(STAT_NOMATCH, 0, 0, 0, 1);
                    else pending[pending.size() - 1].last = 1;
                end
            endcase
        endfunction

        function void check_beat(t_beat got);
            t_beat want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected beat status %0d index %0d", $time, got.status,
                         got.point_index);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status || got.point_index !== want.point_index ||
                got.pt_x !== want.pt_x || got.pt_y !== want.pt_y || got.pt_z !== want.pt_z ||
                got.found !== want.found || got.last !== want.last) begin
                $display("%0t: mismatch expected st=%0d idx=%0d pt=%h/%h/%h f=%b l=%b",
                         $time, want.status, want.point_index, want.pt_x, want.pt_y,
                         want.pt_z, want.found, want.last);
                $display("%0t:          actual   st=%0d idx=%0d pt=%h/%h/%h f=%b l=%b",
                         $time, got.status, got.point_index, got.pt_x, got.pt_y,
                         got.pt_z, got.found, got.last);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               psel, penable, pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               start;
    logic               busy;
    logic [1:0]         i_req_type;
    logic signed [31:0] i_pos_x, i_pos_y, i_pos_z;
    logic [30:0]        i_radius;
    logic               o_valid;
    logic [2:0]         o_status;
    logic [8:0]         o_point_index;
    logic signed [31:0] o_pt_x, o_pt_y, o_pt_z;
    logic               o_found, o_last;

    grid_scoreboard sb;
    int             cycles;
    bit             quiet_sender;   // no idling during this stretch

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SPAN        = 4 << 16;   // coordinates mostly within +-4.0

    hash_grid_neighbor_search uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // results cannot be held off: sample every strobe
    always @(posedge i_clk) begin
        t_beat b;
        if (i_rst_n && o_valid) begin
            b.status      = t_status'(o_status);
            b.point_index = o_point_index;
            b.pt_x        = o_pt_x;
            b.pt_y        = o_pt_y;
            b.pt_z        = o_pt_z;
            b.found       = o_found;
            b.last        = o_last;
            sb.check_beat(b);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("hash_grid_neighbor_search regression: fail");
            $finish;
        end
    end

    // register write: setup cycle then access cycle
    task automatic write_reg(t_reg_idx r, logic [31:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sb.set_reg(r, v);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // wait for every beat to arrive and the block to go idle
    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        do @(posedge i_clk); while (busy);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_grid(logic [4:0] rx, logic [4:0] ry, logic [4:0] rz, logic [31:0] inv);
        drain();
        write_reg(REG_RES_X, {27'd0, rx});
        write_reg(REG_RES_Y, {27'd0, ry});
        write_reg(REG_RES_Z, {27'd0, rz});
        write_reg(REG_INV_SPC, inv);
    endtask

    // one request beat; start stays high if another follows at once
    task automatic send(t_req rq, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                        logic [30:0] rad);
        if (!start || (!quiet_sender && $urandom_range(0, 99) < 21)) begin
            if (start) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        i_req_type <= rq;
        i_pos_x    <= x;
        i_pos_y    <= y;
        i_pos_z    <= z;
        i_radius   <= rad;
        start      <= 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note_request(rq, x, y, z, rad);
    endtask

    task automatic stop_sending();
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 99) < 80) return $urandom_range(0, 2 * SPAN) - SPAN;
        return $urandom;
    endfunction

    function automatic logic [30:0] rand_radius();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7) return 31'($urandom_range(0, 3 << 16));
        if (sel < 9) return 31'($urandom);
        return 31'd0;
    endfunction

    task automatic random_items(int count);
        int sel;
        t_req rq;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 3) rq = REQ_CLEAR;
            else if (sel < 45) rq = REQ_ADD;
            else if (sel < 78) rq = REQ_QALL;
            else rq = REQ_QANY;
            send(rq, rand_coord(), rand_coord(), rand_coord(), rand_radius());
        end
        stop_sending();
    endtask

    initial begin
        sb           = new();
        cycles       = 0;
        quiet_sender = 0;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        start        = 1'b0;
        i_req_type   = REQ_CLEAR;
        i_pos_x      = '0;
        i_pos_y      = '0;
        i_pos_z      = '0;
        i_radius     = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset grid, extremes, bucket overflow, no-match and any-queries
        send(REQ_ADD, 32'd0, 32'd0, 32'd0, 31'd0);
        send(REQ_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
        send(REQ_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'd0);
        for (int k = 0; k < 9; k++)   // ninth add into one cell overflows the bucket
            send(REQ_ADD, 32'h0000_4000 + k, 32'h0000_2000, 32'h0000_C000, 31'd0);
        send(REQ_QALL, 32'h0000_4000, 32'h0000_2000, 32'h0000_C000, 31'h0000_0100);
        send(REQ_QALL, 32'h0000_4000, 32'h0000_2000, 32'h0000_C000, 31'd0);
        send(REQ_QALL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
        send(REQ_QALL, 32'h0050_0000, 32'h0050_0000, 32'h0050_0000, 31'd1);
        send(REQ_QANY, 32'h0000_4000, 32'h0000_2000, 32'h0000_C000, 31'h7FFF_FFFF);
        send(REQ_QANY, 32'h0050_0000, 32'h0050_0000, 32'h0050_0000, 31'd0);
        send(REQ_QANY, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'd0);
        send(REQ_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
        send(REQ_QALL, 32'd0, 32'd0, 32'd0, 31'h7FFF_FFFF);
        stop_sending();

        // one cell per axis: all 8 keys alias, a full bucket gives 64 matches
        set_grid(5'd1, 5'd1, 5'd1, 32'h0001_0000);
        for (int k = 0; k < 8; k++)
            send(REQ_ADD, $urandom_range(0, 2 * SPAN) - SPAN,
                 $urandom_range(0, 2 * SPAN) - SPAN,
                 $urandom_range(0, 2 * SPAN) - SPAN, 31'd0);
        send(REQ_QALL, 32'd0, 32'd0, 32'd0, 31'h7FFF_FFFF);
        stop_sending();
        drain();   // sender holds off until nothing is outstanding
        send(REQ_QANY, 32'd0, 32'd0, 32'd0, 31'h7FFF_FFFF);
        send(REQ_CLEAR, 32'd0, 32'd0, 32'd0, 31'd0);
        random_items(25);

        // long stretch without sender idling
        quiet_sender = 1;
        set_grid(5'd16, 5'd16, 5'd16, 32'h0000_8000);
        random_items(25);
        quiet_sender = 0;

        // out-of-range resolutions clamp, narrowest spacing
        set_grid(5'd0, 5'd31, 5'd3, 32'hFFFF_FFFF);
        random_items(25);

        // zero inverse spacing: every point in cell 0
        set_grid(5'd5, 5'd2, 5'd16, 32'd0);
        random_items(20);

        set_grid(5'd16, 5'd16, 5'd16, 32'd1);
        random_items(20);

        // unit spacing on the full grid
        set_grid(5'd16, 5'd16, 5'd16, 32'h0001_0000);
        random_items(20);

        set_grid(5'd8, 5'd8, 5'd8, 32'h0001_0000);
        random_items(15);

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (700) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("hash_grid_neighbor_search regression: pass");
        else
            $display("hash_grid_neighbor_search regression: fail");
        $finish;
    end
endmodule
